FILE: rtl/timed_blind_tilt_position_tracker_top_defines.svh
`ifndef TIMED_BLIND_TILT_POSITION_TRACKER_TOP_DEFINES_SVH
`define TIMED_BLIND_TILT_POSITION_TRACKER_TOP_DEFINES_SVH

// same-cycle implication, checked on clk, off during rst
`define TBTPT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on clk, off during rst
`define TBTPT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/tbtpt_pkg.sv
package tbtpt_pkg;

  localparam int CNT_W     = 20;
  localparam int REQ_W     = 11;
  localparam int DLY_W     = 16;
  localparam int ELAP_W    = 17;
  localparam int OP_W      = 2;
  localparam int FRAC_SH   = 10;
  localparam int PROD_W    = REQ_W + CNT_W;
  localparam int CFG_W     = 20;
  localparam int CFG_IDX_W = 2;
  localparam int IN_W      = 16;
  localparam int OUT_W     = 48;
  localparam int Q_DEPTH   = 4;
  localparam int Q_PTR_W   = 2;

  localparam logic [REQ_W-1:0]  FRAC_ONE = REQ_W'(1 << FRAC_SH);
  localparam logic [ELAP_W-1:0] ELAP_MAX = '1;

  localparam logic [CNT_W-1:0] OPEN_RST      = CNT_W'(60000);
  localparam logic [CNT_W-1:0] CLOSE_RST     = CNT_W'(60000);
  localparam logic [CNT_W-1:0] TILT_RST      = CNT_W'(1500);
  localparam logic [DLY_W-1:0] DLY_RST       = DLY_W'(0);
  localparam logic [CNT_W:0]   NEED_RST      = (CNT_W+1)'(TILT_RST) + (CNT_W+1)'(DLY_RST);
  localparam logic [CNT_W-1:0] NET_OPEN_RST  = CNT_W'((CNT_W+1)'(OPEN_RST) - NEED_RST);
  localparam logic [CNT_W-1:0] NET_CLOSE_RST = CNT_W'((CNT_W+1)'(CLOSE_RST) - NEED_RST);

  typedef enum logic [OP_W-1:0] {
    OP_TICK = 2'd0,
    OP_STOP = 2'd1,
    OP_POS  = 2'd2,
    OP_TILT = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OPEN  = 2'd0,
    REG_CLOSE = 2'd1,
    REG_TILT  = 2'd2,
    REG_DELAY = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic             wr;
    logic             fault;
    logic [CNT_W-1:0] net_open;
    logic [CNT_W-1:0] net_close;
    logic [CNT_W-1:0] tilt_time;
    logic [DLY_W-1:0] delay;
  } cfg_t;

  typedef struct packed {
    logic [CNT_W-1:0] pos_den;
    logic [CNT_W-1:0] tilt_den;
  } den_t;

  typedef struct packed {
    op_t               op;
    logic [REQ_W-1:0]  req;
    logic [PROD_W-1:0] p_open;
    logic [PROD_W-1:0] p_close;
    logic [PROD_W-1:0] p_tilt;
    logic [PROD_W-1:0] p_pden;
    logic [PROD_W-1:0] p_tden;
  } qent_t;

endpackage

FILE: rtl/tbtpt_front.sv
module tbtpt_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [tbtpt_pkg::IN_W-1:0]     s_tdata,   // operation, request_fraction
  input  logic                           cfg_we,
  input  logic [tbtpt_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  logic [tbtpt_pkg::CFG_W-1:0]    cfg_wdata,
  input  logic                           q_full,
  output logic                           push,
  output tbtpt_pkg::qent_t               push_data,
  input  tbtpt_pkg::den_t                den,
  output tbtpt_pkg::cfg_t                cfg
);

  logic [tbtpt_pkg::CNT_W-1:0] open_time, close_time, tilt_time;
  logic [tbtpt_pkg::DLY_W-1:0] delay;
  logic [tbtpt_pkg::CNT_W-1:0] open_next, close_next, tilt_next;
  logic [tbtpt_pkg::DLY_W-1:0] delay_next;
  logic [tbtpt_pkg::CNT_W:0]   need_next;
  logic                        fault, fault_next;
  logic [tbtpt_pkg::CNT_W-1:0] net_open, net_close, net_open_next, net_close_next;
  logic [tbtpt_pkg::REQ_W-1:0] req_raw, req_sat;

  always_comb begin
    open_next  = open_time;
    close_next = close_time;
    tilt_next  = tilt_time;
    delay_next = delay;
    if (cfg_we) begin
      unique case (tbtpt_pkg::reg_idx_t'(cfg_addr))
        tbtpt_pkg::REG_OPEN:  open_next  = cfg_wdata;
        tbtpt_pkg::REG_CLOSE: close_next = cfg_wdata;
        tbtpt_pkg::REG_TILT:  tilt_next  = cfg_wdata;
        tbtpt_pkg::REG_DELAY: delay_next = cfg_wdata[tbtpt_pkg::DLY_W-1:0];
        default: ;
      endcase
    end
    need_next = (tbtpt_pkg::CNT_W+1)'(tilt_next) + (tbtpt_pkg::CNT_W+1)'(delay_next);
    fault_next = ((tbtpt_pkg::CNT_W+1)'(open_next) < need_next) ||
                 ((tbtpt_pkg::CNT_W+1)'(close_next) < need_next);
    net_open_next  = tbtpt_pkg::CNT_W'((tbtpt_pkg::CNT_W+1)'(open_next) - need_next);
    net_close_next = tbtpt_pkg::CNT_W'((tbtpt_pkg::CNT_W+1)'(close_next) - need_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      open_time  <= tbtpt_pkg::OPEN_RST;
      close_time <= tbtpt_pkg::CLOSE_RST;
      tilt_time  <= tbtpt_pkg::TILT_RST;
      delay      <= tbtpt_pkg::DLY_RST;
      fault      <= 1'b0;
      net_open   <= tbtpt_pkg::NET_OPEN_RST;
      net_close  <= tbtpt_pkg::NET_CLOSE_RST;
    end else begin
      open_time  <= open_next;
      close_time <= close_next;
      tilt_time  <= tilt_next;
      delay      <= delay_next;
      fault      <= fault_next;
      net_open   <= net_open_next;
      net_close  <= net_close_next;
    end
  end

  assign cfg.wr        = cfg_we;
  assign cfg.fault     = fault;
  assign cfg.net_open  = net_open;
  assign cfg.net_close = net_close;
  assign cfg.tilt_time = tilt_time;
  assign cfg.delay     = delay;

  // classify the beat and form every product the back end may need
  assign req_raw  = s_tdata[tbtpt_pkg::OP_W +: tbtpt_pkg::REQ_W];
  assign req_sat  = (req_raw > tbtpt_pkg::FRAC_ONE) ? tbtpt_pkg::FRAC_ONE : req_raw;
  assign s_tready = !q_full;
  assign push     = s_tvalid && s_tready;

  assign push_data.op      = tbtpt_pkg::op_t'(s_tdata[tbtpt_pkg::OP_W-1:0]);
  assign push_data.req     = req_sat;
  assign push_data.p_open  = tbtpt_pkg::PROD_W'(req_sat) * tbtpt_pkg::PROD_W'(net_open);
  assign push_data.p_close = tbtpt_pkg::PROD_W'(req_sat) * tbtpt_pkg::PROD_W'(net_close);
  assign push_data.p_tilt  = tbtpt_pkg::PROD_W'(req_sat) * tbtpt_pkg::PROD_W'(tilt_time);
  assign push_data.p_pden  = tbtpt_pkg::PROD_W'(req_sat) * tbtpt_pkg::PROD_W'(den.pos_den);
  assign push_data.p_tden  = tbtpt_pkg::PROD_W'(req_sat) * tbtpt_pkg::PROD_W'(den.tilt_den);

endmodule

FILE: rtl/tbtpt_queue.sv
`include "timed_blind_tilt_position_tracker_top_defines.svh"

module tbtpt_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  tbtpt_pkg::qent_t push_data,
  output logic             full,
  input  logic             pop,
  output logic             q_valid,
  output tbtpt_pkg::qent_t q_data
);

  tbtpt_pkg::qent_t                 entries [tbtpt_pkg::Q_DEPTH];
  logic [tbtpt_pkg::Q_PTR_W-1:0]    wr_ptr, rd_ptr;
  logic [tbtpt_pkg::Q_PTR_W:0]      count;

  assign full    = count == (tbtpt_pkg::Q_PTR_W+1)'(tbtpt_pkg::Q_DEPTH);
  assign q_valid = count != '0;
  assign q_data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `TBTPT_ASSERT_NOW(a_q_no_overflow, push, !full, "queue written while full")
  `TBTPT_ASSERT_NOW(a_q_no_underflow, pop, count != '0, "queue read while empty")

endmodule

FILE: rtl/tbtpt_back.sv
`include "timed_blind_tilt_position_tracker_top_defines.svh"

module tbtpt_back (
  input  logic                        clk,
  input  logic                        rst,
  input  tbtpt_pkg::cfg_t             cfg,
  input  logic                        q_valid,
  input  tbtpt_pkg::qent_t            q_data,
  output logic                        pop,
  output tbtpt_pkg::den_t             den,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [tbtpt_pkg::OUT_W-1:0] m_tdata  // motor_drive, position_count, tilt_count,
                                               // target_reached, fault
);

  localparam int WIDE_W = tbtpt_pkg::PROD_W + 10;
  localparam int TK_W   = tbtpt_pkg::CNT_W + 10;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_OPEN  = 2'd1,
    MODE_CLOSE = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    SEL_STALE = 2'd0,
    SEL_OPEN  = 2'd1,
    SEL_CLOSE = 2'd2
  } den_sel_t;

  // |r/1024 - num/den| * 1000 < 1, with den zero read as fraction zero
  function automatic logic frac_near(input logic [tbtpt_pkg::REQ_W-1:0] r,
                                     input logic [tbtpt_pkg::PROD_W-1:0] rd,
                                     input logic [tbtpt_pkg::CNT_W-1:0] num,
                                     input logic [tbtpt_pkg::CNT_W-1:0] dn);
    logic [tbtpt_pkg::PROD_W-1:0] b;
    logic [tbtpt_pkg::PROD_W-1:0] diff;
    logic [WIDE_W-1:0]            dx;
    logic [WIDE_W-1:0]            scaled;
    logic [WIDE_W-1:0]            lim;
    b      = tbtpt_pkg::PROD_W'(num) << tbtpt_pkg::FRAC_SH;
    diff   = (rd > b) ? rd - b : b - rd;
    dx     = WIDE_W'(diff);
    // x1000 = x1024 - x16 - x8
    scaled = (dx << 10) - (dx << 4) - (dx << 3);
    lim    = WIDE_W'(dn) << tbtpt_pkg::FRAC_SH;
    if (dn == '0) begin
      return r <= tbtpt_pkg::REQ_W'(1);
    end
    return scaled < lim;
  endfunction

  function automatic logic frac_below(input logic [tbtpt_pkg::PROD_W-1:0] rd,
                                      input logic [tbtpt_pkg::CNT_W-1:0] num,
                                      input logic [tbtpt_pkg::CNT_W-1:0] dn);
    return (dn != '0) && (rd < (tbtpt_pkg::PROD_W'(num) << tbtpt_pkg::FRAC_SH));
  endfunction

  mode_t                        mode, mode_next;
  logic [tbtpt_pkg::CNT_W-1:0]  pos, pos_next, tilt, tilt_next;
  logic [tbtpt_pkg::CNT_W-1:0]  tgt_pos, tgt_pos_next, tgt_tilt, tgt_tilt_next;
  logic [tbtpt_pkg::ELAP_W-1:0] elapsed, elapsed_next;
  logic [tbtpt_pkg::CNT_W-1:0]  pos_den, pos_den_next, tilt_den, tilt_den_next;
  den_sel_t                     pos_sel, pos_sel_next;
  logic                         tilt_cur, tilt_cur_next;

  mode_t                        out_drive;
  logic [tbtpt_pkg::CNT_W-1:0]  out_pos, out_tilt;
  logic                         out_reached, out_fault;

  logic                         fire, reached;
  logic [tbtpt_pkg::REQ_W-1:0]  r;
  logic [tbtpt_pkg::PROD_W-1:0] pr, tr;
  logic                         near_pos, near_tilt, below_pos, below_tilt, tilt_open;
  logic [TK_W-1:0]              tk_ext, t1000;
  logic [tbtpt_pkg::ELAP_W-1:0] elapsed_inc;
  logic                         moving, elapsed_gt, opening, over, at_tgt;
  logic [tbtpt_pkg::CNT_W:0]    tilt_up, tilt_dn, t_raw;
  logic [tbtpt_pkg::CNT_W+1:0]  p_up, p_dn, p_raw;
  logic [tbtpt_pkg::CNT_W-1:0]  pmax, p_clamp, tick_pos, tick_tilt;
  logic                         go_close, start_en, refresh_en;
  mode_t                        start_mode;

  assign fire = q_valid && (!m_tvalid || m_tready);
  assign pop  = fire;
  assign r    = q_data.req;

  // products against the shown denominators
  always_comb begin
    case (pos_sel)
      SEL_OPEN:  pr = q_data.p_open;
      SEL_CLOSE: pr = q_data.p_close;
      default:   pr = q_data.p_pden;
    endcase
    tr = tilt_cur ? q_data.p_tilt : q_data.p_tden;
  end

  assign near_pos   = frac_near(r, pr, pos, pos_den);
  assign near_tilt  = frac_near(r, tr, tilt, tilt_den);
  assign below_pos  = frac_below(pr, pos, pos_den);
  assign below_tilt = frac_below(tr, tilt, tilt_den);
  assign tk_ext     = TK_W'(tilt);
  assign t1000      = (tk_ext << 10) - (tk_ext << 4) - (tk_ext << 3);
  assign tilt_open  = (tilt_den != '0) && (t1000 > TK_W'(tilt_den));

  // one tick of travel
  assign elapsed_inc = (elapsed != tbtpt_pkg::ELAP_MAX) ? elapsed + 1'b1 : elapsed;
  assign moving      = elapsed_inc > tbtpt_pkg::ELAP_W'(cfg.delay);
  assign elapsed_gt  = elapsed > tbtpt_pkg::ELAP_W'(cfg.delay);
  assign opening     = mode == MODE_OPEN;
  assign tilt_up     = (tbtpt_pkg::CNT_W+1)'(tilt) + 1'b1;
  assign tilt_dn     = (tilt == '0) ? '0 : (tbtpt_pkg::CNT_W+1)'(tilt) - 1'b1;
  assign t_raw       = opening ? tilt_up : tilt_dn;
  assign tick_tilt   = !moving ? tilt :
                       (t_raw > (tbtpt_pkg::CNT_W+1)'(cfg.tilt_time)) ? cfg.tilt_time :
                       t_raw[tbtpt_pkg::CNT_W-1:0];
  assign over        = opening ? (tilt >= cfg.tilt_time) : (tilt == '0);
  assign pmax        = opening ? cfg.net_open : cfg.net_close;
  assign p_up        = (tbtpt_pkg::CNT_W+2)'(pos) + (tbtpt_pkg::CNT_W+2)'(tilt_up)
                       - (tbtpt_pkg::CNT_W+2)'(cfg.tilt_time);
  assign p_dn        = (pos == '0) ? '0 : (tbtpt_pkg::CNT_W+2)'(pos) - 1'b1;
  assign p_raw       = opening ? p_up : p_dn;
  assign p_clamp     = (p_raw > (tbtpt_pkg::CNT_W+2)'(pmax)) ? pmax :
                       p_raw[tbtpt_pkg::CNT_W-1:0];
  assign tick_pos    = (moving && over) ? p_clamp : pos;
  assign at_tgt      = opening ? (tick_pos >= tgt_pos && tick_tilt >= tgt_tilt) :
                                 (tick_pos <= tgt_pos && tick_tilt <= tgt_tilt);

  always_comb begin
    mode_next     = mode;
    pos_next      = pos;
    tilt_next     = tilt;
    tgt_pos_next  = tgt_pos;
    tgt_tilt_next = tgt_tilt;
    elapsed_next  = elapsed;
    pos_den_next  = pos_den;
    tilt_den_next = tilt_den;
    pos_sel_next  = pos_sel;
    tilt_cur_next = tilt_cur;
    reached       = 1'b0;
    go_close      = 1'b0;
    start_en      = 1'b0;
    start_mode    = MODE_IDLE;
    refresh_en    = 1'b0;

    if (fire) begin
      if (cfg.fault) begin
        mode_next    = MODE_IDLE;
        elapsed_next = '0;
      end else begin
        unique case (q_data.op)
          tbtpt_pkg::OP_TICK: begin
            if (mode != MODE_IDLE) begin
              elapsed_next = elapsed_inc;
              pos_next     = tick_pos;
              tilt_next    = tick_tilt;
              refresh_en   = moving;
              if (at_tgt) begin
                mode_next    = MODE_IDLE;
                elapsed_next = '0;
                reached      = 1'b1;
              end
            end
          end
          tbtpt_pkg::OP_STOP: begin
            start_en   = 1'b1;
            start_mode = MODE_IDLE;
          end
          tbtpt_pkg::OP_POS: begin
            if (!(near_pos && !(r == '0 && tilt_open))) begin
              go_close      = below_pos || (r == '0);
              tgt_tilt_next = go_close ? '0 : cfg.tilt_time;
              tgt_pos_next  = go_close ? q_data.p_close[tbtpt_pkg::FRAC_SH +: tbtpt_pkg::CNT_W]
                                       : q_data.p_open[tbtpt_pkg::FRAC_SH +: tbtpt_pkg::CNT_W];
              start_en      = 1'b1;
              start_mode    = go_close ? MODE_CLOSE : MODE_OPEN;
            end
          end
          tbtpt_pkg::OP_TILT: begin
            if (!near_tilt) begin
              tgt_pos_next  = pos;
              tgt_tilt_next = q_data.p_tilt[tbtpt_pkg::FRAC_SH +: tbtpt_pkg::CNT_W];
              start_en      = 1'b1;
              start_mode    = below_tilt ? MODE_CLOSE : MODE_OPEN;
            end
          end
        endcase

        // start, direction change or stop; same direction keeps running
        if (start_en && !(start_mode == mode && start_mode != MODE_IDLE)) begin
          refresh_en   = (mode != MODE_IDLE) && elapsed_gt;
          mode_next    = start_mode;
          elapsed_next = '0;
        end

        if (refresh_en) begin
          pos_den_next  = opening ? cfg.net_open : cfg.net_close;
          pos_sel_next  = opening ? SEL_OPEN : SEL_CLOSE;
          tilt_den_next = cfg.tilt_time;
          tilt_cur_next = 1'b1;
        end
      end
    end

    // stored denominators no longer track the registers after a write
    if (cfg.wr) begin
      pos_sel_next  = SEL_STALE;
      tilt_cur_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= MODE_IDLE;
      pos      <= '0;
      tilt     <= '0;
      tgt_pos  <= '0;
      tgt_tilt <= '0;
      elapsed  <= '0;
      pos_den  <= '0;
      tilt_den <= '0;
      pos_sel  <= SEL_STALE;
      tilt_cur <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      mode     <= mode_next;
      pos      <= pos_next;
      tilt     <= tilt_next;
      tgt_pos  <= tgt_pos_next;
      tgt_tilt <= tgt_tilt_next;
      elapsed  <= elapsed_next;
      pos_den  <= pos_den_next;
      tilt_den <= tilt_den_next;
      pos_sel  <= pos_sel_next;
      tilt_cur <= tilt_cur_next;
      if (fire) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_drive   <= mode_next;
      out_pos     <= pos_next;
      out_tilt    <= tilt_next;
      out_reached <= reached;
      out_fault   <= cfg.fault;
    end
  end

  assign den.pos_den  = pos_den;
  assign den.tilt_den = tilt_den;
  assign m_tdata = tbtpt_pkg::OUT_W'({out_fault, out_reached, out_tilt, out_pos, out_drive});

  `TBTPT_ASSERT_NOW(a_reached_stops, m_tvalid && out_reached, out_drive == MODE_IDLE, "target hit but motor still driven")
  `TBTPT_ASSERT_NOW(a_fault_stops, m_tvalid && out_fault, out_drive == MODE_IDLE, "fault beat with motor driven")
  `TBTPT_ASSERT_NOW(a_idle_no_delay, mode == MODE_IDLE, elapsed == '0, "start-up count running while idle")
  `TBTPT_ASSERT_NEXT(a_fault_halts, fire && cfg.fault, mode == MODE_IDLE, "motion continued under fault")

endmodule

FILE: rtl/timed_blind_tilt_position_tracker_top.sv
// channel   dir  signals                      beat contents (lsb first)
// s_*       in   s_tvalid s_tready s_tdata    operation[1:0] request_fraction[12:2]
// m_*       out  m_tvalid m_tready m_tdata    motor_drive[1:0] position_count[21:2]
//                                             tilt_count[41:22] target_reached[42] fault[43]
// cfg_*     in   cfg_we cfg_addr cfg_wdata    0 open, 1 close, 2 tilt, 3 actuator delay
//
// one beat per cycle in and out unless a full queue or a low m_tready stalls; each beat
// is held in the queue, then in the output register; the four-entry queue of precomputed
// products parts the front multipliers from the state update, so either side stalls alone
// rst is synchronous and restores register defaults and a closed, idle blind; no
// clearing pass
module timed_blind_tilt_position_tracker_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [tbtpt_pkg::IN_W-1:0]      s_tdata,   // operation, request_fraction
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [tbtpt_pkg::OUT_W-1:0]     m_tdata,   // motor_drive, position_count,
                                                     // tilt_count, target_reached, fault
  input  logic                            cfg_we,
  input  logic [tbtpt_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  logic [tbtpt_pkg::CFG_W-1:0]     cfg_wdata
);

  logic             q_full, push, pop, q_valid;
  tbtpt_pkg::qent_t push_data, q_data;
  tbtpt_pkg::den_t  den;
  tbtpt_pkg::cfg_t  cfg;

  tbtpt_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data),
    .den       (den),
    .cfg       (cfg)
  );

  tbtpt_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_data    (q_data)
  );

  tbtpt_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_valid  (q_valid),
    .q_data   (q_data),
    .pop      (pop),
    .den      (den),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule
